### hw/rtl/kpd_pkg.sv
// Shared types, constants and the key map for the keypad scanner.
`timescale 1ns / 1ps

package kpd_pkg;

  localparam int unsigned CntW  = 16;  // settle counter width, 4..32
  localparam int unsigned LimW  = 16;  // debounce limit register width
  localparam int unsigned CmpW  = (CntW > LimW) ? CntW : LimW;
  localparam int unsigned RowsW = 4;
  localparam int unsigned ColsW = 3;
  localparam int unsigned CodeW = 4;

  localparam logic [LimW-1:0] LimReset = LimW'(1000);
  localparam logic [CntW-1:0] CntMax   = {CntW{1'b1}};

  typedef enum logic [1:0] {
    PH_SCAN   = 2'd0,
    PH_SETTLE = 2'd1,
    PH_HOLD   = 2'd2
  } phase_e;

  typedef enum logic [1:0] {
    COL_ONE   = 2'd0,
    COL_TWO   = 2'd1,
    COL_THREE = 2'd2
  } col_e;

  // Row-major key map; the last row carries 10, 0, 11.
  function automatic logic [CodeW-1:0] key_map(input logic [1:0] row, input col_e col);
    logic [CodeW-1:0] code;
    code = '0;
    unique case (row)
      2'd0: begin
        case (col)
          COL_TWO:   code = CodeW'(2);
          COL_THREE: code = CodeW'(3);
          default:   code = CodeW'(1);
        endcase
      end
      2'd1: begin
        case (col)
          COL_TWO:   code = CodeW'(5);
          COL_THREE: code = CodeW'(6);
          default:   code = CodeW'(4);
        endcase
      end
      2'd2: begin
        case (col)
          COL_TWO:   code = CodeW'(8);
          COL_THREE: code = CodeW'(9);
          default:   code = CodeW'(7);
        endcase
      end
      default: begin
        case (col)
          COL_TWO:   code = CodeW'(0);
          COL_THREE: code = CodeW'(11);
          default:   code = CodeW'(10);
        endcase
      end
    endcase
    return code;
  endfunction

endpackage

### hw/rtl/keypad_scanner_debounce.sv
// 4x3 keypad scanner with debounce, one row sample per beat.
`timescale 1ns / 1ps

// Each input beat is one tick of sampled row lines; it yields one output beat in
// the next cycle, and a new beat is taken every cycle while the output is taken.
// Rows in a beat belong to the column shown on the previous output beat. The scan
// state, settle counter and latched code are updated at the input handshake and
// drive the output directly; only key_valid and the output valid are held in a
// stage of their own. The user must write the debounce limit through the config
// channel only while the block is idle; the block does not enforce this. A key
// latches once any row has stayed low for that many beats (0 acts as 1).
module keypad_scanner_debounce (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [kpd_pkg::LimW-1:0]   cfg_data_i,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [kpd_pkg::RowsW-1:0]  rows_n_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [kpd_pkg::ColsW-1:0]  cols_n_o,
  output logic                       key_valid_o,
  output logic [kpd_pkg::CodeW-1:0]  key_code_o,
  output logic [kpd_pkg::CodeW-1:0]  leds_n_o
);
  import kpd_pkg::*;

  logic [LimW-1:0]  limit_q;
  phase_e           phase_q, phase_d;
  col_e             col_q, col_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [1:0]       row_q, row_d;
  logic [CodeW-1:0] code_q, code_d;
  logic [CodeW-1:0] leds_q, leds_d;
  logic             kv_q, kv_d;
  logic             ovalid_q;

  logic             accept;
  logic             any_low;
  logic             held_up;
  logic [CntW-1:0]  cnt_inc;
  logic             hit;
  logic [1:0]       low_row;
  col_e             col_adv;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = !ovalid_q || out_ready_i;
  assign accept      = in_valid_i && in_ready_o;

  assign any_low = (rows_n_i != {RowsW{1'b1}});
  assign held_up = rows_n_i[row_q];

  always_comb begin
    cnt_inc = (phase_q == PH_SETTLE) ? cnt_q : '0;
    if (cnt_inc != CntMax) begin
      cnt_inc = cnt_inc + CntW'(1);
    end
  end

  assign hit = (CmpW'(cnt_inc) >= CmpW'(limit_q));

  always_comb begin
    if (!rows_n_i[0]) begin
      low_row = 2'd0;
    end else if (!rows_n_i[1]) begin
      low_row = 2'd1;
    end else if (!rows_n_i[2]) begin
      low_row = 2'd2;
    end else begin
      low_row = 2'd3;
    end
  end

  always_comb begin
    case (col_q)
      COL_TWO:   col_adv = COL_THREE;
      COL_THREE: col_adv = COL_ONE;
      default:   col_adv = COL_TWO;
    endcase
  end

  // Next phase
  always_comb begin
    phase_d = phase_q;
    if (accept) begin
      unique case (phase_q)
        PH_HOLD: begin
          if (held_up) phase_d = PH_SCAN;
        end
        default: begin
          if (!any_low) begin
            phase_d = PH_SCAN;
          end else if (hit) begin
            phase_d = PH_HOLD;
          end else begin
            phase_d = PH_SETTLE;
          end
        end
      endcase
    end
  end

  // Datapath updates
  always_comb begin
    col_d  = col_q;
    cnt_d  = cnt_q;
    row_d  = row_q;
    code_d = code_q;
    leds_d = leds_q;
    kv_d   = 1'b0;
    if (accept && phase_q != PH_HOLD) begin
      if (!any_low) begin
        cnt_d = '0;
        col_d = col_adv;
      end else if (hit) begin
        cnt_d  = '0;
        row_d  = low_row;
        code_d = key_map(low_row, col_q);
        leds_d = ~key_map(low_row, col_q);
        kv_d   = 1'b1;
      end else begin
        cnt_d = cnt_inc;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q  <= LimReset;
      phase_q  <= PH_SCAN;
      col_q    <= COL_ONE;
      cnt_q    <= '0;
      row_q    <= 2'd0;
      code_q   <= '0;
      leds_q   <= {CodeW{1'b1}};
      kv_q     <= 1'b0;
      ovalid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        limit_q <= cfg_data_i;
      end
      phase_q <= phase_d;
      col_q   <= col_d;
      cnt_q   <= cnt_d;
      row_q   <= row_d;
      code_q  <= code_d;
      leds_q  <= leds_d;
      if (accept) begin
        kv_q     <= kv_d;
        ovalid_q <= 1'b1;
      end else if (out_ready_i) begin
        ovalid_q <= 1'b0;
      end
    end
  end

  always_comb begin
    unique case (col_q)
      COL_TWO:   cols_n_o = 3'b101;
      COL_THREE: cols_n_o = 3'b011;
      default:   cols_n_o = 3'b110;
    endcase
  end

  assign out_valid_o = ovalid_q;
  assign key_valid_o = kv_q;
  assign key_code_o  = code_q;
  assign leds_n_o    = leds_q;

endmodule

### hw/rtl/kpd_checker.sv
// Port-level checks for the keypad scanner, bound to the top level.
`timescale 1ns / 1ps

module kpd_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid_i,
  input logic                       in_ready_o,
  input logic                       out_valid_o,
  input logic                       out_ready_i,
  input logic [kpd_pkg::ColsW-1:0]  cols_n_o,
  input logic                       key_valid_o,
  input logic [kpd_pkg::CodeW-1:0]  key_code_o,
  input logic [kpd_pkg::CodeW-1:0]  leds_n_o
);
  import kpd_pkg::*;

  // A stalled output beat holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(cols_n_o)
      && $stable(key_valid_o) && $stable(key_code_o) && $stable(leds_n_o))
    else $error("output beat changed while stalled");

  a_one_col: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> $onehot(~cols_n_o))
    else $error("column drive not one-cold");

  a_leds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> leds_n_o == ~key_code_o)
    else $error("LEDs do not mirror key code");

  a_code_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && key_valid_o |-> !(key_code_o == 4'd12 || key_code_o == 4'd13
      || key_code_o == 4'd14 || key_code_o == 4'd15))
    else $error("latched key code out of range");

  // Output stage never refuses input while empty.
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled with empty output stage");

endmodule

bind keypad_scanner_debounce kpd_checker u_kpd_checker (.*);

### dv/testbench.sv
// Self-checking testbench for the keypad scanner: row-sample stimulus, scan predictor, scoreboard.
`timescale 1ns / 1ps

import kpd_pkg::*;

typedef struct packed {
  logic [ColsW-1:0] cols_n;
  logic             key_valid;
  logic [CodeW-1:0] key_code;
  logic [CodeW-1:0] leds_n;
} scan_beat_t;

// Tracks scan/debounce state per row sample and holds the output beats still owed.
class scan_tracker;
  phase_e           phase;
  col_e             col;
  logic [CntW-1:0]  settle;
  logic [1:0]       held_row;
  logic [CodeW-1:0] code;
  logic [CodeW-1:0] leds;
  logic [LimW-1:0]  limit;
  scan_beat_t       owed_beats[$];
  int               mismatches;

  function new();
    phase      = PH_SCAN;
    col        = COL_ONE;
    settle     = '0;
    held_row   = '0;
    code       = '0;
    leds       = '1;
    limit      = 16'd1000;
    mismatches = 0;
  endfunction

  function void set_limit(input logic [LimW-1:0] value);
    limit = value;
  endfunction

  function int pending();
    return owed_beats.size();
  endfunction

  function logic [CodeW-1:0] code_of(input logic [1:0] row, input col_e c);
    if (row == 2'd3) begin
      case (c)
        COL_TWO:   return CodeW'(0);
        COL_THREE: return CodeW'(11);
        default:   return CodeW'(10);
      endcase
    end
    return CodeW'(int'(row) * 3 + int'(c) + 1);
  endfunction

  function void note_rows(input logic [RowsW-1:0] rows);
    scan_beat_t b;
    b.key_valid = 1'b0;
    if (phase == PH_HOLD) begin
      // only the held row matters; release tick does not advance the column
      if (rows[held_row]) phase = PH_SCAN;
    end else if (rows == '1) begin
      phase  = PH_SCAN;
      settle = '0;
      case (col)
        COL_ONE: col = COL_TWO;
        COL_TWO: col = COL_THREE;
        default: col = COL_ONE;
      endcase
    end else begin
      if (phase != PH_SETTLE) begin
        phase  = PH_SETTLE;
        settle = '0;
      end
      if (settle != '1) settle++;
      // a limit of zero latches on the first low sample
      if (32'(settle) >= 32'(limit)) begin
        held_row    = !rows[0] ? 2'd0 : !rows[1] ? 2'd1 : !rows[2] ? 2'd2 : 2'd3;
        code        = code_of(held_row, col);
        leds        = ~code;
        b.key_valid = 1'b1;
        phase       = PH_HOLD;
        settle      = '0;
      end
    end
    b.cols_n   = ~(ColsW'(1) << col);
    b.key_code = code;
    b.leds_n   = leds;
    owed_beats.push_back(b);
  endfunction

  task report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 40) $display("[%0t] mismatch: %s", $time, msg);
  endtask

  task check_beat(input scan_beat_t got);
    scan_beat_t want;
    if (owed_beats.size() == 0) begin
      report_mismatch("output beat with nothing owed");
      return;
    end
    want = owed_beats.pop_front();
    if (got.cols_n !== want.cols_n)
      report_mismatch($sformatf("cols_n %h, want %h", got.cols_n, want.cols_n));
    if (got.key_valid !== want.key_valid)
      report_mismatch($sformatf("key_valid %b, want %b", got.key_valid, want.key_valid));
    if (got.key_code !== want.key_code)
      report_mismatch($sformatf("key_code %0d, want %0d", got.key_code, want.key_code));
    if (got.leds_n !== want.leds_n)
      report_mismatch($sformatf("leds_n %h, want %h", got.leds_n, want.leds_n));
  endtask
endclass

module testbench;

  localparam int RunLimit = 400_000;

  logic              clk_i       = 1'b0;
  logic              rst_ni      = 1'b0;
  logic              cfg_valid_i = 1'b0;
  logic [LimW-1:0]   cfg_data_i  = '0;
  logic              in_valid_i  = 1'b0;
  logic [RowsW-1:0]  rows_n_i    = '1;
  logic              out_ready_i = 1'b0;
  logic              hold_off    = 1'b0;
  logic              cfg_ready_o;
  logic              in_ready_o;
  logic              out_valid_o;
  logic [ColsW-1:0]  cols_n_o;
  logic              key_valid_o;
  logic [CodeW-1:0]  key_code_o;
  logic [CodeW-1:0]  leds_n_o;

  int idle_pct   = 0;
  int stall_pct  = 0;
  int rows_sent  = 0;
  int cycles     = 0;
  int cur_limit  = 1000;
  scan_tracker tracker = new();

  always #1 clk_i = ~clk_i;

  keypad_scanner_debounce u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .rows_n_i    (rows_n_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cols_n_o    (cols_n_o),
    .key_valid_o (key_valid_o),
    .key_code_o  (key_code_o),
    .leds_n_o    (leds_n_o)
  );

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > RunLimit) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // output side: check taken beats, then pick next ready
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i)
      tracker.check_beat(scan_beat_t'{cols_n_o, key_valid_o, key_code_o, leds_n_o});
    out_ready_i <= !hold_off && ($urandom_range(99) >= stall_pct);
  end

  task automatic send_rows(input logic [RowsW-1:0] rows);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    rows_n_i   <= rows;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    tracker.note_rows(rows);
    rows_sent++;
  endtask

  task automatic write_limit(input logic [LimW-1:0] value);
    in_valid_i <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    tracker.set_limit(value);
    cur_limit = int'(value);
  endtask

  // one key press: optional bounce, a hold around the limit with jitter on other rows,
  // then release
  task automatic press_key();
    logic [RowsW-1:0] pat;
    logic [RowsW-1:0] rows;
    int lim;
    int n_hold;
    int low_row;
    lim = (cur_limit == 0) ? 1 : cur_limit;
    pat = RowsW'($urandom_range(14));
    low_row = 0;
    while (pat[low_row]) low_row++;
    repeat ($urandom_range(3)) send_rows('1);
    if ($urandom_range(2) == 0) begin
      repeat ($urandom_range(3, 1)) begin
        send_rows(pat);
        send_rows('1);
      end
    end
    n_hold = $urandom_range(lim + 4, (lim > 2) ? lim - 2 : 1);
    repeat (n_hold) begin
      rows = pat;
      if ($urandom_range(3) == 0) begin
        rows = RowsW'($urandom_range(15));
        rows[low_row] = 1'b0;
      end
      send_rows(rows);
    end
    repeat ($urandom_range(3, 1)) send_rows('1);
  endtask

  task automatic run_phase(input int idle, input int stall, input logic [LimW-1:0] lim,
                           input int n);
    int goal;
    write_limit(lim);
    idle_pct  = idle;
    stall_pct = stall;
    goal = rows_sent + n;
    while (rows_sent < goal) begin
      if ($urandom_range(4) == 0)
        repeat ($urandom_range(6, 1)) send_rows(RowsW'($urandom_range(15)));
      else
        press_key();
    end
  endtask

  initial begin
    logic [RowsW-1:0] quick_seq[] = '{4'hF, 4'h0, 4'h0, 4'h1, 4'h7, 4'h6, 4'hF, 4'hF,
                                      4'hB, 4'hF, 4'hF, 4'h5, 4'hF};
    logic [RowsW-1:0] bounce_seq[] = '{4'hF, 4'hE, 4'hF, 4'hE, 4'hD, 4'hB, 4'h6, 4'hF, 4'hF};
    int goal;

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // default limit straight out of reset: a short press must not latch
    send_rows('1);
    repeat (20) send_rows(4'b1110);
    send_rows('1);

    // zero limit: all rows low, release tick, last row alone, other rows while holding
    write_limit('0);
    foreach (quick_seq[i]) send_rows(quick_seq[i]);

    // limit 3: release during debounce, then a changing pattern that latches
    write_limit(LimW'(3));
    foreach (bounce_seq[i]) send_rows(bounce_seq[i]);

    run_phase(0, 0, LimW'(1), 75);
    run_phase(57, 0, LimW'(3), 75);
    run_phase(0, 57, LimW'($urandom_range(12, 2)), 75);
    run_phase(33, 33, LimW'(2), 75);

    // output held off while rows keep coming, so the input side backs up
    write_limit(LimW'(2));
    idle_pct  = 0;
    stall_pct = 0;
    fork
      begin
        hold_off <= 1'b1;
        for (int n = 0; n < 300; n++) @(posedge clk_i);
        hold_off <= 1'b0;
      end
      begin
        goal = rows_sent + 40;
        while (rows_sent < goal) press_key();
      end
    join

    // widest limit: a short press never reaches it
    write_limit('1);
    send_rows('1);
    repeat (20) send_rows(4'b0111);
    send_rows('1);
    send_rows('1);

    in_valid_i <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (tracker.mismatches == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule
